@@ rtl/lpfd_pkg.sv @@
package lpfd_pkg;

    // parser phase
    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_DATA
    } phase_t;

    // configuration register indexes
    localparam int unsigned CfgIndexW = 1;
    localparam logic [CfgIndexW-1:0] CFG_TARGET_MASK    = 1'b0;
    localparam logic [CfgIndexW-1:0] CFG_OPERATION_MASK = 1'b1;

    localparam logic [7:0] TARGET_MASK_RST    = 8'h0F;
    localparam logic [7:0] OPERATION_MASK_RST = 8'hF0;

    // length byte codes
    localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;

    // one result item
    typedef struct packed {
        logic [7:0]  frame_target;
        logic [7:0]  frame_operation;
        logic [63:0] frame_length;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last;
    } result_t;

    // front to queue
    typedef struct packed {
        logic    valid;
        result_t rec;
    } q_push_t;

    // queue to front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ rtl/lpfd_if.sv @@
interface lpfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpfd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_target;
    logic [7:0]  frame_operation;
    logic [63:0] frame_length;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        last;

    modport source (
        output valid, output frame_target, output frame_operation,
        output frame_length, output data_byte, output has_data, output last,
        input ready
    );
    modport sink (
        input valid, input frame_target, input frame_operation,
        input frame_length, input data_byte, input has_data, input last,
        output ready
    );
endinterface

@@ rtl/lpfd_front.sv @@
module lpfd_front
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lpfd_in_if.sink    stream,
    input  logic [7:0] target_mask,
    input  logic [7:0] operation_mask,
    input  q_status_t  q_stat,
    output q_push_t    q_push
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  tgt_reg, tgt_next;
    logic [7:0]  op_reg, op_next;
    logic [3:0]  ext_reg, ext_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] left_reg, left_next;

    logic        accept;
    logic [7:0]  b;
    logic [6:0]  len7;
    logic        short_len;
    logic [63:0] acc_ext;
    logic [3:0]  ext_dec;
    logic [63:0] left_dec;

    assign stream.ready = !q_stat.full;
    assign accept       = stream.valid && !q_stat.full;
    assign b            = stream.in_byte;
    assign len7         = b[6:0];
    assign short_len    = (len7 <= LEN_SHORT_MAX);
    assign acc_ext      = {len_reg[55:0], b};
    assign ext_dec      = (ext_reg != 4'd0) ? ext_reg - 4'd1 : 4'd0;
    assign left_dec     = (left_reg != 64'd0) ? left_reg - 64'd1 : 64'd0;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR0:
                    phase_next = PH_HDR1;
                PH_HDR1:
                begin
                    if (!short_len)
                        phase_next = PH_EXT;
                    else if (len7 == 7'd0)
                        phase_next = PH_HDR0;
                    else
                        phase_next = PH_DATA;
                end
                PH_EXT:
                begin
                    if (ext_dec == 4'd0)
                        phase_next = (acc_ext == 64'd0) ? PH_HDR0 : PH_DATA;
                end
                PH_DATA:
                begin
                    if (left_dec == 64'd0)
                        phase_next = PH_HDR0;
                end
                default:
                    phase_next = PH_HDR0;
            endcase
        end
    end

    // datapath and result push
    always_comb
    begin
        tgt_next              = tgt_reg;
        op_next               = op_reg;
        ext_next              = ext_reg;
        len_next              = len_reg;
        left_next             = left_reg;
        q_push.valid          = 1'b0;
        q_push.rec.data_byte  = 8'd0;
        q_push.rec.has_data   = 1'b0;
        q_push.rec.last       = 1'b1;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    tgt_next = b & target_mask;
                    op_next  = b & operation_mask;
                end
                PH_HDR1:
                begin
                    if (short_len)
                    begin
                        len_next  = {57'd0, len7};
                        left_next = {57'd0, len7};
                        // zero length gives the empty marker
                        q_push.valid = (len7 == 7'd0);
                    end
                    else
                    begin
                        len_next = 64'd0;
                        ext_next = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    end
                end
                PH_EXT:
                begin
                    len_next = acc_ext;
                    ext_next = ext_dec;
                    if (ext_dec == 4'd0)
                    begin
                        left_next    = acc_ext;
                        q_push.valid = (acc_ext == 64'd0);
                    end
                end
                PH_DATA:
                begin
                    left_next            = left_dec;
                    q_push.valid         = 1'b1;
                    q_push.rec.data_byte = b;
                    q_push.rec.has_data  = 1'b1;
                    q_push.rec.last      = (left_dec == 64'd0);
                end
                default:
                    ;
            endcase
        end
        q_push.rec.frame_target    = tgt_reg;
        q_push.rec.frame_operation = op_reg;
        q_push.rec.frame_length    = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            tgt_reg   <= 8'd0;
            op_reg    <= 8'd0;
            ext_reg   <= 4'd0;
            len_reg   <= 64'd0;
            left_reg  <= 64'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            tgt_reg   <= tgt_next;
            op_reg    <= op_next;
            ext_reg   <= ext_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

endmodule

@@ rtl/lpfd_queue.sv @@
module lpfd_queue
    import lpfd_pkg::*;
#(
    parameter int unsigned Depth = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_push_t   q_push,
    input  logic      pop,
    output result_t   head,
    output q_status_t q_stat
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] Full    = CntW'(Depth);

    result_t         mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign q_stat.full  = (cnt_reg == Full);
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = q_push.valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= q_push.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/lpfd_back.sv @@
module lpfd_back
    import lpfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_stat,
    input  result_t   head,
    output logic      pop,
    lpfd_out_if.source frames
);

    logic    valid_reg, valid_next;
    result_t rec_reg;

    // refill the output register when it is empty or being taken
    assign pop        = !q_stat.empty && (!valid_reg || frames.ready);
    assign valid_next = pop ? 1'b1 : (valid_reg && !frames.ready);

    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign frames.valid           = valid_reg;
    assign frames.frame_target    = rec_reg.frame_target;
    assign frames.frame_operation = rec_reg.frame_operation;
    assign frames.frame_length    = rec_reg.frame_length;
    assign frames.data_byte       = rec_reg.data_byte;
    assign frames.has_data        = rec_reg.has_data;
    assign frames.last            = rec_reg.last;

endmodule

@@ rtl/length_prefixed_frame_deframer_core.sv @@
// length-prefixed frame deframer: takes one stream byte per cycle and splits the
// stream into frames. header byte 0 is masked with target_mask and
// operation_mask (taken at that byte, so a later write affects the next frame);
// the low 7 bits of header byte 1 give the length, 126 and 127 selecting a
// 2-byte or 8-byte big-endian extended length. every payload byte comes out as
// one item with the frame's target, operation and full 64-bit length, last set
// on the final byte; a zero-length frame gives one item with has_data clear.
// no other header or length byte gives an item. rate: one byte per cycle,
// sustained, as long as the sink takes items; the parser updates its phase
// and 64-bit payload counter on every accepted byte. a result is pushed into
// a QueueDepth-entry queue at the edge that accepts its byte, and the output
// stage pulls it into its register once that register is empty or being
// taken by the sink. with the sink stalled, up to QueueDepth + 1 results are
// held before stream.ready drops. there is no clearing pass after reset.
// config writes (cfg_we, cfg_index, cfg_data) take effect at the clock edge
// and are meant for an idle block.
module length_prefixed_frame_deframer_core
    import lpfd_pkg::*;
#(
    parameter int unsigned QueueDepth = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    lpfd_in_if.sink              stream,
    lpfd_out_if.source           frames,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    // configuration registers
    logic [7:0] target_mask_reg, target_mask_next;
    logic [7:0] operation_mask_reg, operation_mask_next;

    // front to queue to back
    q_push_t   q_push;
    q_status_t q_stat;
    result_t   head;
    logic      pop;

    always_comb
    begin
        target_mask_next    = target_mask_reg;
        operation_mask_next = operation_mask_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_MASK:    target_mask_next    = cfg_data;
                CFG_OPERATION_MASK: operation_mask_next = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_mask_reg    <= TARGET_MASK_RST;
            operation_mask_reg <= OPERATION_MASK_RST;
        end
        else
        begin
            target_mask_reg    <= target_mask_next;
            operation_mask_reg <= operation_mask_next;
        end
    end

    // header parsing and payload counting
    lpfd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .stream         (stream),
        .target_mask    (target_mask_reg),
        .operation_mask (operation_mask_reg),
        .q_stat         (q_stat),
        .q_push         (q_push)
    );

    // decouples the parser from output stalls
    lpfd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    // output register
    lpfd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .frames (frames)
    );

    // the parser never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> !q_stat.full)
        else $error("push into full queue");

    // an empty-frame marker always closes its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (frames.valid && !frames.has_data) |-> frames.last)
        else $error("empty marker without last");

    // an empty-frame marker carries zero length and no data
    assert property (@(posedge clk) disable iff (!rst_n)
        (frames.valid && !frames.has_data) |->
            (frames.frame_length == 64'd0 && frames.data_byte == 8'd0))
        else $error("empty marker with length or data");

    // the output stage only refills from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

@@ test/length_prefixed_frame_deframer_core_tb.sv @@
`timescale 1ns / 100ps

module length_prefixed_frame_deframer_core_tb;
    import lpfd_pkg::*;

    // how the length of a frame is spelled in its header
    typedef enum logic [1:0] {
        LEN_FORM_SHORT,
        LEN_FORM_EXT16,
        LEN_FORM_EXT64
    } len_form_t;

    // length byte code for the 8-byte form
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // bytes of random frames per phase, and the run limit
    localparam int unsigned PHASE_BYTES = 425;
    localparam int unsigned NUM_PHASES  = 4;
    localparam int unsigned TIMEOUT_NS  = 5_000_000;

    // ring buffers for pending bytes and expected results
    localparam int unsigned RING_W     = 12;
    localparam int unsigned RING_DEPTH = 1 << RING_W;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = CFG_TARGET_MASK;
    logic [7:0]           cfg_data  = 8'h00;

    lpfd_in_if  stream_if ();
    lpfd_out_if frames_if ();

    length_prefixed_frame_deframer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .frames    (frames_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // stream bytes waiting to be offered, and results still owed by the block
    logic [7:0]  pending_mem [RING_DEPTH];
    result_t     expected_mem [RING_DEPTH];
    int unsigned pend_wr = 0;
    int unsigned pend_rd = 0;
    int unsigned exp_wr  = 0;
    int unsigned exp_rd  = 0;

    // predictor copy of the masks and the parser state
    logic [7:0]  tgt_mask;
    logic [7:0]  op_mask;
    phase_t      model_phase;
    logic [7:0]  model_target;
    logic [7:0]  model_operation;
    logic [3:0]  model_ext_left;
    logic [63:0] model_length;
    logic [63:0] model_remaining;

    // handshake bookkeeping and idling control
    logic        in_taken;
    int unsigned in_gap       = 0;
    int unsigned out_gap      = 0;
    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;
    int unsigned fail_count   = 0;

    result_t seen_result;
    result_t want_result;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // one result of the current frame goes onto the expected list
    function automatic void push_expected(input logic [7:0] data, input logic has,
                                          input logic fin);
        result_t r;
        r.frame_target    = model_target;
        r.frame_operation = model_operation;
        r.frame_length    = model_length;
        r.data_byte       = data;
        r.has_data        = has;
        r.last            = fin;
        expected_mem[exp_wr[RING_W-1:0]] = r;
        exp_wr++;
    endfunction

    // length fully known: either an empty-frame marker or into the payload
    function automatic void open_payload();
        if (model_length == 64'd0)
        begin
            push_expected(8'h00, 1'b0, 1'b1);
            model_phase = PH_HDR0;
        end
        else
        begin
            model_remaining = model_length;
            model_phase     = PH_DATA;
        end
    endfunction

    // advance the parser by one accepted stream byte
    function automatic void deframe_byte(input logic [7:0] b);
        case (model_phase)
            PH_HDR0:
            begin
                // masks are taken here, later writes only touch the next frame
                model_target    = b & tgt_mask;
                model_operation = b & op_mask;
                model_phase     = PH_HDR1;
            end
            PH_HDR1:
            begin
                // bit 7 of the length byte plays no part
                if (b[6:0] <= LEN_SHORT_MAX)
                begin
                    model_length = 64'(b[6:0]);
                    open_payload();
                end
                else
                begin
                    model_length   = 64'd0;
                    model_ext_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    model_phase    = PH_EXT;
                end
            end
            PH_EXT:
            begin
                // big-endian, non-minimal values are taken as they are
                model_length = {model_length[55:0], b};
                if (model_ext_left != 4'd0)
                    model_ext_left--;
                if (model_ext_left == 4'd0)
                    open_payload();
            end
            default:
            begin
                if (model_remaining != 64'd0)
                    model_remaining--;
                push_expected(b, 1'b1, model_remaining == 64'd0);
                if (model_remaining == 64'd0)
                    model_phase = PH_HDR0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // monitor: register writes, accepted stream items, checked results
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_mask        = TARGET_MASK_RST;
            op_mask         = OPERATION_MASK_RST;
            model_phase     = PH_HDR0;
            model_target    = 8'h00;
            model_operation = 8'h00;
            model_ext_left  = 4'd0;
            model_length    = 64'd0;
            model_remaining = 64'd0;
            exp_rd          = exp_wr;
            in_taken <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET_MASK:    tgt_mask = cfg_data;
                    CFG_OPERATION_MASK: op_mask  = cfg_data;
                    default:            ;
                endcase
            end

            // tells the driver at the next falling edge that its item went in
            in_taken <= stream_if.valid && stream_if.ready;
            if (stream_if.valid && stream_if.ready)
                deframe_byte(stream_if.in_byte);

            if (frames_if.valid && frames_if.ready)
            begin
                seen_result.frame_target    = frames_if.frame_target;
                seen_result.frame_operation = frames_if.frame_operation;
                seen_result.frame_length    = frames_if.frame_length;
                seen_result.data_byte       = frames_if.data_byte;
                seen_result.has_data        = frames_if.has_data;
                seen_result.last            = frames_if.last;
                if (exp_wr == exp_rd)
                    report_mismatch($sformatf("result item with none expected: %p",
                                              seen_result));
                else
                begin
                    want_result = expected_mem[exp_rd[RING_W-1:0]];
                    exp_rd++;
                    if (seen_result.frame_target !== want_result.frame_target)
                        report_mismatch($sformatf("frame_target %h, expected %h",
                            seen_result.frame_target, want_result.frame_target));
                    if (seen_result.frame_operation !== want_result.frame_operation)
                        report_mismatch($sformatf("frame_operation %h, expected %h",
                            seen_result.frame_operation, want_result.frame_operation));
                    if (seen_result.frame_length !== want_result.frame_length)
                        report_mismatch($sformatf("frame_length %h, expected %h",
                            seen_result.frame_length, want_result.frame_length));
                    if (seen_result.data_byte !== want_result.data_byte)
                        report_mismatch($sformatf("data_byte %h, expected %h",
                            seen_result.data_byte, want_result.data_byte));
                    if (seen_result.has_data !== want_result.has_data)
                        report_mismatch($sformatf("has_data %b, expected %b",
                            seen_result.has_data, want_result.has_data));
                    if (seen_result.last !== want_result.last)
                        report_mismatch($sformatf("last %b, expected %b",
                            seen_result.last, want_result.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stream driver: offers pending bytes, holds an item until it is taken,
    // and idles in bursts only between items
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                pend_rd++;
            if (!stream_if.valid || in_taken)
            begin
                if (in_gap != 0)
                begin
                    in_gap--;
                    stream_if.valid <= 1'b0;
                end
                else if (pend_wr != pend_rd && $urandom_range(1, 100) <= in_idle_pct)
                begin
                    // burst of idle cycles, this one included
                    in_gap = $urandom_range(0, 13);
                    stream_if.valid <= 1'b0;
                end
                else if (pend_wr != pend_rd)
                begin
                    stream_if.valid   <= 1'b1;
                    stream_if.in_byte <= pending_mem[pend_rd[RING_W-1:0]];
                end
                else
                    stream_if.valid <= 1'b0;
            end
        end
    end

    // result sink: stalls in random bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap != 0)
            begin
                out_gap--;
                frames_if.ready <= 1'b0;
            end
            else if ($urandom_range(1, 100) <= out_idle_pct)
            begin
                out_gap = $urandom_range(0, 13);
                frames_if.ready <= 1'b0;
            end
            else
                frames_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        pending_mem[pend_wr[RING_W-1:0]] = b;
        pend_wr++;
    endfunction

    // header, length field in the chosen form, then random payload bytes
    function automatic void queue_frame(input logic [7:0] hdr, input len_form_t form,
                                        input logic top, input logic [63:0] length,
                                        input int unsigned payload_bytes);
        int i;
        push_byte(hdr);
        case (form)
            LEN_FORM_SHORT:
                push_byte({top, length[6:0]});
            LEN_FORM_EXT16:
            begin
                push_byte({top, LEN_EXT16});
                push_byte(length[15:8]);
                push_byte(length[7:0]);
            end
            default:
            begin
                push_byte({top, LEN_EXT64});
                for (i = 7; i >= 0; i--)
                    push_byte(length[8*i +: 8]);
            end
        endcase
        repeat (payload_bytes)
            push_byte(8'($urandom));
    endfunction

    // wait until every item is in and every result is out, then let the
    // parser settle on any trailing header bytes
    task automatic wait_quiet();
        while (pend_wr != pend_rd || stream_if.valid || exp_wr != exp_rd)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // both masks, back to back, only while the block is quiet
    task automatic set_masks(input logic [7:0] tgt, input logic [7:0] op);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TARGET_MASK;
        cfg_data  <= tgt;
        @(negedge clk);
        cfg_index <= CFG_OPERATION_MASK;
        cfg_data  <= op;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned ph;
        int unsigned pick;
        len_form_t   form;
        logic [63:0] length;

        stream_if.valid   = 1'b0;
        stream_if.in_byte = 8'h00;
        frames_if.ready   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames under the reset masks
        in_idle_pct  = 10;
        out_idle_pct = 10;
        // empty frame with an all-ones header
        queue_frame(8'hFF, LEN_FORM_SHORT, 1'b0, 64'd0, 0);
        // top bit of the length byte set, one payload byte
        queue_frame(8'h00, LEN_FORM_SHORT, 1'b1, 64'd1, 1);
        // 2-byte form carrying zero gives the empty marker
        queue_frame(8'h3C, LEN_FORM_EXT16, 1'b1, 64'd0, 0);
        // 8-byte form with a non-minimal length
        queue_frame(8'h5A, LEN_FORM_EXT64, 1'b0, 64'd2, 2);
        // mask change after header byte 0 must not touch this frame
        push_byte(8'h96);
        wait_quiet();
        set_masks(8'hFF, 8'h00);
        push_byte(8'h01);
        push_byte(8'($urandom));
        wait_quiet();

        // random frames, one mask setting and idling mix per phase
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    in_idle_pct  = 8;
                    out_idle_pct = 8;
                end
                1:
                begin
                    set_masks(8'h00, 8'hFF);
                    in_idle_pct  = 0;
                    out_idle_pct = 12;
                end
                2:
                begin
                    set_masks(8'($urandom), 8'($urandom));
                    in_idle_pct  = 12;
                    out_idle_pct = 0;
                end
                default:
                begin
                    set_masks(8'hA5, 8'h5A);
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase

            while (pend_wr - pend_rd < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    form   = LEN_FORM_SHORT;
                    length = 64'd0;
                end
                else if (pick < 8)
                begin
                    // longest short length and its neighborhood
                    form   = LEN_FORM_SHORT;
                    length = (pick == 5) ? 64'd125 : 64'($urandom_range(100, 125));
                end
                else if (pick < 80)
                begin
                    form   = LEN_FORM_SHORT;
                    length = 64'($urandom_range(1, 16));
                end
                else
                begin
                    // extended forms: zero, small non-minimal, or past the short range
                    form = (pick < 92) ? LEN_FORM_EXT16 : LEN_FORM_EXT64;
                    case ($urandom_range(0, 9))
                        0:       length = 64'd0;
                        1:       length = 64'($urandom_range(126, 300));
                        default: length = 64'($urandom_range(1, 40));
                    endcase
                end
                queue_frame(8'($urandom), form, 1'($urandom), length, 32'(length));
            end

            // a huge length never finishes, so it closes the run
            if (ph == NUM_PHASES - 1)
                queue_frame(8'($urandom), LEN_FORM_EXT64, 1'($urandom),
                            64'hFFFF_FFFF_FFFF_FFFF, 40);
            wait_quiet();
        end

        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
